>>> hw/rtl/lms_pkg.sv
`default_nettype none
package lms_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned ResultW = 22;
  localparam int unsigned FracW   = 16;
  localparam int unsigned QDepth  = 4;
  localparam int unsigned QPtrW   = 2;

  // One sample as it travels from the front queue to the back end
  typedef struct packed {
    logic               last;
    logic [SampleW-1:0] value;
  } item_t;

  // One summary result, packed as it leaves on tdata
  typedef struct packed {
    logic               overflowed;
    logic               zero_median;
    logic [ResultW-1:0] log2_median;
  } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/lms_queue.sv
`default_nettype none
module lms_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_valid_i,
  output logic               push_ready_o,
  input  wire lms_pkg::item_t push_item_i,
  output logic               pop_valid_o,
  input  wire logic          pop_ready_i,
  output lms_pkg::item_t     pop_item_o
);

  lms_pkg::item_t                 slot_q [lms_pkg::QDepth];
  logic [lms_pkg::QPtrW-1:0]      wptr_q, rptr_q;
  logic [lms_pkg::QPtrW:0]        fill_q;
  logic                           push, pop;

  assign push_ready_o = (fill_q != (lms_pkg::QPtrW+1)'(lms_pkg::QDepth));
  assign pop_valid_o  = (fill_q != '0);
  assign pop_item_o   = slot_q[rptr_q];
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      if (push && !pop)      fill_q <= fill_q + 1'b1;
      else if (pop && !push) fill_q <= fill_q - 1'b1;
    end
  end

  // Slot storage
  always_ff @(posedge clk_i) begin
    if (push) slot_q[wptr_q] <= push_item_i;
  end

endmodule
`default_nettype wire

>>> hw/rtl/lms_back.sv
`default_nettype none
module lms_back #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire lms_pkg::item_t in_item_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lms_pkg::result_t    out_result_o
);

  localparam int unsigned AddrW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SW    = lms_pkg::SampleW;

  typedef enum logic [2:0] {
    StIdle, StInit, StSweep, StNorm, StMul, StAdj, StOut
  } state_e;

  state_e              state_q;
  logic [SW-1:0]       mem_q [MAX_SAMPLES];
  logic [SW-1:0]       rdata_q;
  logic                rvalid_q;
  logic [CntW-1:0]     cnt_q, rd_addr_q, ra_q, rb_q, ca_q, cb_q;
  logic                ovf_q;
  logic [SW-1:0]       pa_q, pb_q, hm_q, bit_q;
  logic [31:0]         m_q;
  logic [63:0]         prod_q;
  logic [4:0]          e_q;
  logic [4:0]          k_q;
  logic [lms_pkg::FracW-1:0] frac_q;
  logic                zero_q;
  logic                out_valid_q;
  lms_pkg::result_t    out_q;

  logic                accept, issue, sweep_end;
  logic                hit_a, hit_b;
  logic [CntW-1:0]     ca_all, cb_all;
  logic [SW:0]         sum;
  logic [32:0]         sq;
  logic [5:0]          ex;

  assign in_ready_o   = (state_q == StIdle);
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

  // Radix select sweep: count entries matching each prefix with current bit clear
  assign issue     = (state_q == StSweep) && (rd_addr_q != cnt_q);
  assign sweep_end = (state_q == StSweep) && (rd_addr_q == cnt_q) && rvalid_q;
  assign hit_a  = rvalid_q && ((rdata_q & hm_q) == (pa_q & hm_q));
  assign hit_b  = rvalid_q && ((rdata_q & hm_q) == (pb_q & hm_q));
  assign ca_all = ca_q + CntW'(hit_a);
  assign cb_all = cb_q + CntW'(hit_b);
  assign sum    = {1'b0, pa_q} + {1'b0, pb_q};
  assign sq     = prod_q[63:31];
  assign ex     = {1'b0, e_q} - 6'd9;

  // Sample store
  always_ff @(posedge clk_i) begin
    if (accept && (cnt_q < CntW'(MAX_SAMPLES))) mem_q[cnt_q[AddrW-1:0]] <= in_item_i.value;
    if (issue) rdata_q <= mem_q[rd_addr_q[AddrW-1:0]];
  end

  // Control sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      rvalid_q    <= 1'b0;
      rd_addr_q   <= '0;
      out_valid_q <= 1'b0;
      ra_q <= '0; rb_q <= '0; ca_q <= '0; cb_q <= '0;
      pa_q <= '0; pb_q <= '0; hm_q <= '0; bit_q <= '0;
      m_q <= '0; prod_q <= '0; e_q <= '0; k_q <= '0; frac_q <= '0; zero_q <= 1'b0;
      out_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != StOut)) out_valid_q <= 1'b0;
      rvalid_q <= issue;
      case (state_q)
        StIdle: begin
          if (accept) begin
            if (cnt_q < CntW'(MAX_SAMPLES)) cnt_q <= cnt_q + 1'b1;
            else                            ovf_q <= 1'b1;
            if (in_item_i.last) state_q <= StInit;
          end
        end
        StInit: begin
          ra_q      <= (cnt_q - 1'b1) >> 1;
          rb_q      <= cnt_q >> 1;
          ca_q      <= '0;
          cb_q      <= '0;
          pa_q      <= '0;
          pb_q      <= '0;
          hm_q      <= {1'b1, {(SW-1){1'b0}}};
          bit_q     <= {1'b1, {(SW-1){1'b0}}};
          rd_addr_q <= '0;
          state_q   <= StSweep;
        end
        StSweep: begin
          if (issue) rd_addr_q <= rd_addr_q + 1'b1;
          if (sweep_end) begin
            ca_q      <= '0;
            cb_q      <= '0;
            rd_addr_q <= '0;
            if (ra_q >= ca_all) begin
              pa_q <= pa_q | bit_q;
              ra_q <= ra_q - ca_all;
            end
            if (rb_q >= cb_all) begin
              pb_q <= pb_q | bit_q;
              rb_q <= rb_q - cb_all;
            end
            if (bit_q[0]) begin
              state_q <= StNorm;
              e_q     <= 5'd24;
              k_q     <= '0;
              frac_q  <= '0;
            end else begin
              bit_q <= bit_q >> 1;
              hm_q  <= hm_q | (hm_q >> 1);
            end
          end else begin
            ca_q <= ca_all;
            cb_q <= cb_all;
          end
          // Load the mantissa once the final bit is decided (next cycle in StNorm)
        end
        StNorm: begin
          if (k_q == '0 && e_q == 5'd24 && !zero_q && m_q == '0) begin
            // first visit: pick up the doubled median, bit 24 lands on bit 31
            m_q    <= {sum, 7'd0};
            zero_q <= (sum == '0);
            k_q    <= 5'd31;
          end else if (zero_q) begin
            state_q <= StOut;
          end else if (m_q[31]) begin
            k_q     <= '0;
            state_q <= StMul;
          end else begin
            m_q <= m_q << 1;
            e_q <= e_q - 1'b1;
          end
        end
        StMul: begin
          prod_q  <= m_q * m_q;
          state_q <= StAdj;
        end
        StAdj: begin
          frac_q <= {frac_q[lms_pkg::FracW-2:0], sq[32]};
          m_q    <= sq[32] ? sq[32:1] : sq[31:0];
          k_q    <= k_q + 1'b1;
          state_q <= (k_q == 5'(lms_pkg::FracW - 1)) ? StOut : StMul;
        end
        StOut: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q       <= 1'b1;
            out_q.overflowed  <= ovf_q;
            out_q.zero_median <= zero_q;
            out_q.log2_median <= zero_q ? '0 : {ex, frac_q};
            cnt_q   <= '0;
            ovf_q   <= 1'b0;
            zero_q  <= 1'b0;
            m_q     <= '0;
            e_q     <= '0;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/log2_median_summarizer.sv
`default_nettype none
// Median log2 summariser: stream in one column of 24-bit intensities (8 fraction
// bits), tlast on the final sample; one result per column gives log2 of the median
// in signed Q16 (truncated), with flags for a zero median and for a column longer
// than MAX_SAMPLES (extra samples dropped). Samples are taken one per cycle, while
// the queue has room, into a four-entry queue and then into the sample store. After
// the last sample the back end radix-selects the median with 24 sweeps of the store
// (one store read per cycle), normalises the mantissa and runs 16 squaring steps,
// each a multiply state followed by an adjust state.
module log2_median_summarizer #(
  parameter int unsigned MAX_SAMPLES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // sample_value[23:0]
  input  wire logic        s_axis_tlast,   // last_sample
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata    // log2_median[21:0], zero_median, overflowed
);

  lms_pkg::item_t   in_item, q_item;
  lms_pkg::result_t res;
  logic             q_valid, q_ready;

  assign in_item.value = s_axis_tdata;
  assign in_item.last  = s_axis_tlast;
  assign m_axis_tdata  = res;

  lms_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (s_axis_tvalid),
    .push_ready_o (s_axis_tready),
    .push_item_i  (in_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_item_o   (q_item)
  );

  lms_back #(.MAX_SAMPLES(MAX_SAMPLES)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_item_i    (q_item),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_result_o (res)
  );

endmodule
`default_nettype wire
